/* hdl/box_blur_3x3_edge_aware_macros.svh */
// Assertion macros for the box blur RTL, used by the back part.
// Needs clk and rst_n in scope where a macro is used.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BB3_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bb3_pkg.sv */
// Package for the 3x3 box blur: types, constants and the reciprocal table.
// Used by every module of the block but bb3_ram; depends on nothing.
package bb3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int CFG_W          = 11;
    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;
    localparam int PIX_W          = 24;
    localparam int QDEPTH         = 4;
    localparam int QPTR_W         = 2;
    localparam int SUM_W          = 12;
    localparam int CNT_W          = 4;
    localparam int NUM_W          = 13;
    localparam int RECIP_W        = 18;
    localparam int RECIP_SHIFT    = 18;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } bb3_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV
    } bb3_state_t;

    // Head of the queue between the front and back parts.
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pix;
    } bb3_qhead_t;

    // Ceiling of 2^18 / (2 * count); exact division for numerators below 2^13.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        unique case (cnt)
            4'd2:    r = 18'd65536;
            4'd3:    r = 18'd43691;
            4'd4:    r = 18'd32768;
            4'd6:    r = 18'd21846;
            4'd9:    r = 18'd14564;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

endpackage

/* hdl/bb3_ram.sv */
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/bb3_front.sv */
// Front part: accepts items, turns drain ticks into zero pixels and queues them.
// Depends on bb3_pkg.
module bb3_front
    import bb3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             kind,
    input  logic [7:0]       in_red,
    input  logic [7:0]       in_green,
    input  logic [7:0]       in_blue,
    output bb3_qhead_t       head,
    input  logic             pop
);

    logic [PIX_W-1:0]    q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                push;
    logic [PIX_W-1:0]    pix;

    // A drain tick carries a black pixel.
    assign pix      = kind ? '0 : {in_red, in_green, in_blue};
    assign in_stall = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign push     = in_valid && !in_stall;

    assign head.valid = (count_reg != '0);
    assign head.pix   = q_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= pix;
        end
    end

endmodule

/* hdl/bb3_back.sv */
// Back part: line stores, 3x3 window, masked sums and rounded division.
// Depends on bb3_pkg, bb3_ram and the assertion macros.
`include "box_blur_3x3_edge_aware_macros.svh"
module bb3_back
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WW-1:0]    width,
    input  logic [HW-1:0]    height,
    input  bb3_qhead_t       head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_red,
    output logic [7:0]       out_green,
    output logic [7:0]       out_blue,
    output logic             frame_end
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    bb3_state_t          state_reg, state_next;
    logic [CW-1:0]       in_col_reg, in_col_next;
    logic [1:0]          in_row_reg, in_row_next;
    logic [CW-1:0]       out_col_reg, out_col_next;
    logic [RW-1:0]       out_row_reg, out_row_next;
    logic [PIX_W-1:0]    x_reg;
    logic [PIX_W-1:0]    win_reg [9];
    logic [PIX_W-1:0]    upper_rd, middle_rd;
    logic                ram_we;
    logic                shift;
    logic [SUM_W-1:0]    sum_r_reg, sum_g_reg, sum_b_reg;
    logic [SUM_W-1:0]    sum_r, sum_g, sum_b;
    logic [CNT_W-1:0]    cnt_reg, cnt;
    logic                end_reg, end_now;
    logic                out_valid_reg, load_out;
    logic [7:0]          red_reg, green_reg, blue_reg;
    logic                frame_end_reg;
    logic                emit, col_last_in, col_last_out;
    logic [2:0]          rok, cok;
    logic [RECIP_W-1:0]  rcp;
    logic [NUM_W+RECIP_W-1:0] prod_r, prod_g, prod_b;

    // Line stores, read while idle and written back in the next cycle.
    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_col_reg),
        .wdata (middle_rd),
        .raddr (in_col_reg),
        .rdata (upper_rd)
    );

    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_col_reg),
        .wdata (x_reg),
        .raddr (in_col_reg),
        .rdata (middle_rd)
    );

    // Neighbour masks and end of frame for the current output position.
    always_comb
    begin
        rok[0]       = (out_row_reg != '0);
        rok[1]       = 1'b1;
        rok[2]       = (HW'(out_row_reg) + HW'(1)) < height;
        cok[0]       = (out_col_reg != '0);
        cok[1]       = 1'b1;
        cok[2]       = (WW'(out_col_reg) + WW'(1)) < width;
        col_last_out = !cok[2];
        end_now      = !rok[2] && col_last_out;
        col_last_in  = (WW'(in_col_reg) + WW'(1)) >= width;
        emit         = (in_row_reg == 2'd2) || ((in_row_reg == 2'd1) && (in_col_reg != '0));
    end

    // Masked sums over the nine window cells.
    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        cnt   = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (rok[r] && cok[c])
                begin
                    sum_r = sum_r + SUM_W'(win_reg[r*3+c][23:16]);
                    sum_g = sum_g + SUM_W'(win_reg[r*3+c][15:8]);
                    sum_b = sum_b + SUM_W'(win_reg[r*3+c][7:0]);
                    cnt   = cnt + CNT_W'(1);
                end
            end
        end
    end

    // Rounded average as (2*sum + count) times a reciprocal of 2*count.
    always_comb
    begin
        rcp    = recip(cnt_reg);
        prod_r = ({sum_r_reg, 1'b0} + NUM_W'(cnt_reg)) * rcp;
        prod_g = ({sum_g_reg, 1'b0} + NUM_W'(cnt_reg)) * rcp;
        prod_b = ({sum_b_reg, 1'b0} + NUM_W'(cnt_reg)) * rcp;
    end

    // Sequencer: next state, counters and strobes.
    always_comb
    begin
        state_next   = state_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pop          = 1'b0;
        ram_we       = 1'b0;
        shift        = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                ram_we = 1'b1;
                shift  = 1'b1;
                if (col_last_in)
                begin
                    in_col_next = '0;
                    if (in_row_reg != 2'd2)
                    begin
                        in_row_next = in_row_reg + 2'd1;
                    end
                end
                else
                begin
                    in_col_next = in_col_reg + CW'(1);
                end
                state_next = emit ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (end_reg)
                    begin
                        in_col_next  = '0;
                        in_row_next  = '0;
                        out_col_next = '0;
                        out_row_next = '0;
                    end
                    else if (col_last_out)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + RW'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            // Window moves one column left; new column is upper, middle, new pixel.
            if (shift)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= upper_rd;
                win_reg[5] <= middle_rd;
                win_reg[8] <= x_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_reg <= head.pix;
        end
        if (state_reg == ST_SUM)
        begin
            sum_r_reg <= sum_r;
            sum_g_reg <= sum_g;
            sum_b_reg <= sum_b;
            cnt_reg   <= cnt;
            end_reg   <= end_now;
        end
        if (load_out)
        begin
            red_reg       <= prod_r[RECIP_SHIFT +: 8];
            green_reg     <= prod_g[RECIP_SHIFT +: 8];
            blue_reg      <= prod_b[RECIP_SHIFT +: 8];
            frame_end_reg <= end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign frame_end = frame_end_reg;

    `BB3_ASSERT_NOW(a_pop_idle, pop, (state_reg == ST_IDLE) && head.valid, "pop outside idle")
    `BB3_ASSERT_NOW(a_cnt_nonzero, state_reg == ST_DIV, cnt_reg != '0, "empty neighbourhood")
    `BB3_ASSERT_NEXT(a_end_clears, load_out && end_reg, (out_col_reg == '0) && (out_row_reg == '0) && (in_row_reg == 2'd0), "counters not cleared at frame end")
    `BB3_ASSERT_NEXT(a_read_after_pop, pop, state_reg == ST_READ, "read did not follow pop")

endmodule

/* hdl/box_blur_3x3_edge_aware.sv */
// An accepted item waits in the input queue until the back sequencer pops it in idle; it then
// passes the read, sum and divide states, and the result is registered once the receiver is ready.
// The back sequencer takes no new item before it is back in idle: after the registered read of
// the line stores, an item with no result returns from read, one with a result passes sum and divide.
// Reset clears counters, window, queue and size (1024 x 1024), not the line stores.
// Top level: configuration registers, front queue and back datapath.
module box_blur_3x3_edge_aware
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             kind,
    input  logic [7:0]       in_red,
    input  logic [7:0]       in_green,
    input  logic [7:0]       in_blue,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_red,
    output logic [7:0]       out_green,
    output logic [7:0]       out_blue,
    output logic             frame_end
);

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int CMPW = (WW > CFG_W) ? WW : CFG_W;
    localparam int CMPH = (HW > CFG_W) ? HW : CFG_W;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [WW-1:0]    width;
    logic [HW-1:0]    height;
    bb3_qhead_t       head;
    logic             pop;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bb3_cfg_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // Sizes clamped to the range 1 to the maximum.
    always_comb
    begin
        if (width_reg == '0)
        begin
            width = WW'(1);
        end
        else if (CMPW'(width_reg) > CMPW'(MAX_WIDTH))
        begin
            width = WW'(MAX_WIDTH);
        end
        else
        begin
            width = WW'(width_reg);
        end
        if (height_reg == '0)
        begin
            height = HW'(1);
        end
        else if (CMPH'(height_reg) > CMPH'(MAX_HEIGHT))
        begin
            height = HW'(MAX_HEIGHT);
        end
        else
        begin
            height = HW'(height_reg);
        end
    end

    bb3_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .in_red   (in_red),
        .in_green (in_green),
        .in_blue  (in_blue),
        .head     (head),
        .pop      (pop)
    );

    bb3_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .width     (width),
        .height    (height),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .frame_end (frame_end)
    );

endmodule
